// ===== sv/msie_pkg.sv =====
// Package for the MIPS subset execute block: sizes, operation codes and the
// item, memory request and execute result structs.
// Depends on nothing; every other file of the block imports it.
package msie_pkg;

  localparam int REG_COUNT     = 32;
  localparam int DATA_DEPTH    = 1024;
  // Program depth must be a power of two: PC arithmetic wraps by truncation.
  localparam int PROGRAM_DEPTH = 1024;

  localparam int DATA_W   = 32;
  localparam int RIDX_W   = $clog2(REG_COUNT);
  localparam int DADDR_W  = $clog2(DATA_DEPTH);
  localparam int PC_W     = $clog2(PROGRAM_DEPTH);
  localparam int FPC_W    = 10;  // width of the next_pc field
  localparam int FADDR_W  = 10;  // width of the mem_address field

  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_ADD  = 4'd1,
    OP_ADDI = 4'd2,
    OP_SUB  = 4'd3,
    OP_MUL  = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_SLL  = 4'd7,
    OP_SRL  = 4'd8,
    OP_LW   = 4'd9,
    OP_SW   = 4'd10,
    OP_BEQ  = 4'd11,
    OP_J    = 4'd12
  } op_t;

  typedef struct packed {
    logic [3:0]         operation;
    logic [4:0]         src_reg;
    logic [4:0]         tgt_reg;
    logic [4:0]         dst_reg;
    logic [4:0]         shift_amount;
    logic signed [15:0] immediate;
    logic [9:0]         jump_target;
  } in_t;

  typedef struct packed {
    logic [FPC_W-1:0]         next_pc;
    logic                     reg_write_enable;
    logic [4:0]               reg_write_index;
    logic signed [DATA_W-1:0] reg_write_value;
    logic                     mem_write_enable;
    logic [FADDR_W-1:0]       mem_address;
    logic                     branch_taken;
    logic                     address_fault;
  } out_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [DADDR_W-1:0] idx;
    logic [DATA_W-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic               reg_we;
    logic [RIDX_W-1:0]  widx;
    logic [DATA_W-1:0]  wval;
    logic               is_load;
    logic               mem_written;
    logic [FADDR_W-1:0] mem_address;
    logic               branch_taken;
    logic               fault;
    logic [PC_W-1:0]    next_pc;
    mem_req_t           mem;
  } exec_t;

endpackage

// ===== sv/msie_exec.sv =====
// Execute logic: ALU, effective address with range check, branch and jump
// target. Purely combinational. Depends on msie_pkg.
module msie_exec (
  input  msie_pkg::in_t                    item,
  input  logic [msie_pkg::PC_W-1:0]        pc,
  input  logic [msie_pkg::DATA_W-1:0]      src_val,
  input  logic [msie_pkg::DATA_W-1:0]      tgt_val,
  output msie_pkg::exec_t                  res
);
  import msie_pkg::*;

  logic [DATA_W-1:0] imm_ext;
  logic [DATA_W-1:0] eff_addr;
  logic [DATA_W-1:0] prod;
  logic [PC_W-1:0]   pc_inc;
  logic              addr_bad;

  assign imm_ext  = {{(DATA_W-16){item.immediate[15]}}, item.immediate};
  assign eff_addr = src_val + imm_ext;
  assign prod     = src_val * tgt_val;
  assign pc_inc   = pc + PC_W'(1);
  assign addr_bad = eff_addr[DATA_W-1] || (eff_addr >= DATA_W'(DATA_DEPTH));

  always_comb begin
    res              = '0;
    res.next_pc      = pc_inc;
    res.mem.idx      = eff_addr[DADDR_W-1:0];
    res.mem.wdata    = tgt_val;
    unique case (op_t'(item.operation))
      OP_ADD: begin
        res.reg_we = 1'b1; res.widx = item.dst_reg; res.wval = src_val + tgt_val;
      end
      OP_ADDI: begin
        res.reg_we = 1'b1; res.widx = item.tgt_reg; res.wval = src_val + imm_ext;
      end
      OP_SUB: begin
        res.reg_we = 1'b1; res.widx = item.dst_reg; res.wval = src_val - tgt_val;
      end
      OP_MUL: begin
        res.reg_we = 1'b1; res.widx = item.dst_reg; res.wval = prod;
      end
      OP_AND: begin
        res.reg_we = 1'b1; res.widx = item.dst_reg; res.wval = src_val & tgt_val;
      end
      OP_OR: begin
        res.reg_we = 1'b1; res.widx = item.dst_reg; res.wval = src_val | tgt_val;
      end
      OP_SLL: begin
        res.reg_we = 1'b1; res.widx = item.dst_reg; res.wval = tgt_val << item.shift_amount;
      end
      OP_SRL: begin
        res.reg_we = 1'b1; res.widx = item.dst_reg; res.wval = tgt_val >> item.shift_amount;
      end
      OP_LW: begin
        res.mem_address = eff_addr[FADDR_W-1:0];
        res.fault       = addr_bad;
        res.mem.en      = !addr_bad;
        res.reg_we      = !addr_bad;
        res.widx        = item.tgt_reg;
        res.is_load     = 1'b1;
      end
      OP_SW: begin
        res.mem_address = eff_addr[FADDR_W-1:0];
        res.fault       = addr_bad;
        res.mem.en      = !addr_bad;
        res.mem.we      = 1'b1;
        res.mem_written = !addr_bad;
      end
      OP_BEQ: begin
        if (src_val == tgt_val) begin
          res.branch_taken = 1'b1;
          res.next_pc      = pc_inc + imm_ext[PC_W-1:0];
        end
      end
      OP_J: begin
        res.branch_taken = 1'b1;
        res.next_pc      = PC_W'(item.jump_target);
      end
      OP_NOP: ;
      default: ;
    endcase
    // register 0 is never written: drop the write and its fields
    if (!res.reg_we || res.widx == '0) begin
      res.reg_we  = 1'b0;
      res.widx    = '0;
      res.wval    = '0;
      res.is_load = 1'b0;
    end
  end

endmodule

// ===== sv/msie_dmem.sv =====
// Data memory: single port, registered read, cleared by a sweep after reset.
// Depends on msie_pkg.
module msie_dmem (
  input  logic                         clk,
  input  logic                         rst,
  input  msie_pkg::mem_req_t           req,
  output logic [msie_pkg::DATA_W-1:0]  rdata,
  output logic                         busy
);
  import msie_pkg::*;

  logic [DATA_W-1:0]  mem [DATA_DEPTH];
  logic [DADDR_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + DADDR_W'(1);
      if (clr_idx == DADDR_W'(DATA_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= '0;
    end else if (req.en && req.we) begin
      mem[req.idx] <= req.wdata;
    end
    if (req.en && !req.we) begin
      rdata <= mem[req.idx];
    end
  end

endmodule

// ===== sv/mips_subset_instruction_execute.sv =====
// Top level of the MIPS subset execute block: input stage with register
// file, execute stage, write-back and result register.
// Depends on msie_pkg, msie_exec and msie_dmem.
//
//   channel  payload        handshake                  direction
//   -------  -------------  -------------------------  ---------
//   instr    msie_pkg::in_t  instr_valid / instr_stall  in
//   result   msie_pkg::out_t result_valid / result_stall out
//
// Throughput is one item per cycle while result_stall is low and the data
// memory is not being cleared. In order, the input register holds an item
// with its operands, the execute stage registers it along with the data
// memory read, and write-back loads the result register; the memory's
// registered read port sets the middle stage. Reset (rst, synchronous)
// empties the pipe and starts a sweep that clears the data memory, one word
// a cycle, over all DATA_DEPTH (1024) words; instr_stall stays high until it
// ends. A stalled result holds; stages behind it fill until the pipe is full.
module mips_subset_instruction_execute (
  input  logic           clk,
  input  logic           rst,
  input  msie_pkg::in_t  instr,
  input  logic           instr_valid,
  output logic           instr_stall,
  output msie_pkg::out_t result,
  output logic           result_valid,
  input  logic           result_stall
);
  import msie_pkg::*;

  // register file with per-entry valid bits (unwritten entries read zero)
  logic [DATA_W-1:0]    rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid;

  // stage 1: decoded item and its operands
  logic              s1_valid;
  in_t               s1_item;
  logic [DATA_W-1:0] s1_a;
  logic [DATA_W-1:0] s1_b;
  logic [PC_W-1:0]   pc;

  // stage 2: executed item, waiting for load data
  logic              s2_valid;
  exec_t             s2;

  logic              in_acc;
  logic              out_free;
  logic              s1_adv;
  logic              s1_free;
  logic              s2_adv;
  logic              s2_free;
  logic [DATA_W-1:0] s2_val;
  logic              wb_we;
  logic [RIDX_W-1:0] wb_idx;
  logic [DATA_W-1:0] wb_val;
  logic [DATA_W-1:0] a_fwd;
  logic [DATA_W-1:0] b_fwd;
  exec_t             ex_res;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              dmem_busy;

  // advance a stage when the one ahead is empty or moving
  assign out_free    = !result_valid || !result_stall;
  assign s2_adv      = s2_valid && out_free;
  assign s2_free     = !s2_valid || s2_adv;
  assign s1_adv      = s1_valid && s2_free;
  assign s1_free     = !s1_valid || s1_adv;
  assign instr_stall = !s1_free || dmem_busy;
  assign in_acc      = instr_valid && !instr_stall;

  // write-back happens as stage 2 moves into the result register
  assign s2_val = s2.is_load ? mem_rdata : s2.wval;
  assign wb_we  = s2_adv && s2.reg_we;
  assign wb_idx = s2.widx;
  assign wb_val = s2_val;

  // forward the older, not yet written, item in stage 2
  assign a_fwd = (s2_valid && s2.reg_we && s2.widx == s1_item.src_reg) ? s2_val : s1_a;
  assign b_fwd = (s2_valid && s2.reg_we && s2.widx == s1_item.tgt_reg) ? s2_val : s1_b;

  msie_exec u_exec (
    .item    (s1_item),
    .pc      (pc),
    .src_val (a_fwd),
    .tgt_val (b_fwd),
    .res     (ex_res)
  );

  always_comb begin
    mem_req    = ex_res.mem;
    mem_req.en = ex_res.mem.en && s1_adv;
  end

  msie_dmem u_dmem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (dmem_busy)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      pc           <= '0;
      rf_valid     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
        pc       <= ex_res.next_pc;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (wb_we) begin
        rf_valid[wb_idx] <= 1'b1;
      end
    end
  end

  // register file write, operand capture and tracking of writes that land
  // while an item holds in stage 1
  always_ff @(posedge clk) begin
    if (wb_we) begin
      rf[wb_idx] <= wb_val;
    end
    if (in_acc) begin
      s1_item <= instr;
      if (wb_we && wb_idx == instr.src_reg) begin
        s1_a <= wb_val;
      end else if (rf_valid[instr.src_reg]) begin
        s1_a <= rf[instr.src_reg];
      end else begin
        s1_a <= '0;
      end
      if (wb_we && wb_idx == instr.tgt_reg) begin
        s1_b <= wb_val;
      end else if (rf_valid[instr.tgt_reg]) begin
        s1_b <= rf[instr.tgt_reg];
      end else begin
        s1_b <= '0;
      end
    end else begin
      if (wb_we && wb_idx == s1_item.src_reg) begin
        s1_a <= wb_val;
      end
      if (wb_we && wb_idx == s1_item.tgt_reg) begin
        s1_b <= wb_val;
      end
    end
  end

  // stage 2 and result payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2 <= ex_res;
    end
    if (s2_adv) begin
      result.next_pc          <= FPC_W'(s2.next_pc);
      result.reg_write_enable <= s2.reg_we;
      result.reg_write_index  <= s2.widx;
      result.reg_write_value  <= s2_val;
      result.mem_write_enable <= s2.mem_written;
      result.mem_address      <= s2.mem_address;
      result.branch_taken     <= s2.branch_taken;
      result.address_fault    <= s2.fault;
    end
  end

  // register 0 is never reported as written
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.reg_write_enable) |-> (result.reg_write_index != '0))
    else $error("write to register 0 reported");

  // a faulting access writes nothing
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.address_fault) |->
      (!result.mem_write_enable && !result.reg_write_enable))
    else $error("faulting access produced a write");

  // no item touches the data memory during the clearing sweep
  assert property (@(posedge clk) disable iff (rst)
    dmem_busy |-> (!mem_req.en && !s1_valid))
    else $error("memory access during clearing sweep");

  // sequential flow steps the PC by one
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !ex_res.branch_taken) |=> (pc == $past(pc) + PC_W'(1)))
    else $error("PC did not step by one");

endmodule
